// File: design/cbsd_pkg.sv
// Shared types, codes and constants of the centred boxcar smoother.
`default_nettype none

package cbsd_pkg;

  localparam int SAMPLE_BITS  = 32;
  localparam int FREQ_BITS    = 32;
  localparam int CFG_BITS     = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam int HW_BITS      = 4;
  localparam int FACTOR_BITS  = 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HALF_WINDOW  = 3'd0,
    REG_DECIMATION   = 3'd1,
    REG_SMOOTH_START = 3'd2,
    REG_BAND_LOW     = 3'd3,
    REG_BAND_HIGH    = 3'd4
  } cbsd_reg_e;

  localparam logic [HW_BITS-1:0]     RST_HALF_WINDOW  = 4'd0;
  localparam logic [FACTOR_BITS-1:0] RST_DECIMATION   = 8'd1;
  localparam logic [FREQ_BITS-1:0]   RST_SMOOTH_START = 32'd3355;
  localparam logic [FREQ_BITS-1:0]   RST_BAND_LOW     = 32'd17;
  localparam logic [FREQ_BITS-1:0]   RST_BAND_HIGH    = 32'd25165824;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MAIN,
    ST_EM_RD,
    ST_EM_EVAL,
    ST_EM_DIV,
    ST_EM_OUT,
    ST_FL_STEP,
    ST_FL_CHK,
    ST_FL_SUB
  } cbsd_state_e;

  typedef enum logic [1:0] {
    RD_OLDEST,
    RD_DROP,
    RD_CENTER
  } cbsd_rd_e;

  typedef struct packed {
    logic     idle;
    logic     update;
    logic     set_k;
    logic     step_k;
    logic     drop;
    logic     capture;
    logic     div_start;
    logic     out_load;
    logic     restart;
    cbsd_rd_e rd_sel;
  } cbsd_cmd_t;

  typedef struct packed {
    logic take;
    logic series_end;
    logic main_emit;
    logic k_zero;
    logic flush_sub;
    logic flush_emit;
    logic raw;
    logic div_busy;
    logic out_free;
  } cbsd_status_t;

endpackage

`default_nettype wire

// File: design/cbsd_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module cbsd_div #(
  parameter int DIVIDEND_W = 37,
  parameter int DIVISOR_W  = 6,
  parameter int QUOT_W     = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [QUOT_W-1:0]     quotient_o
);

  localparam int STEP_W = $clog2(QUOT_W + 1);

  logic                 busy_q;
  logic [STEP_W-1:0]    step_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] den_q;
  logic [QUOT_W-1:0]    quo_q;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign shifted = {rem_q, quo_q[QUOT_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(QUOT_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // The quotient fits QUOT_W bits, so the top dividend bits start below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DIVISOR_W'(dividend_i >> QUOT_W);
      quo_q <= dividend_i[QUOT_W-1:0];
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_q <= {quo_q[QUOT_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: design/cbsd_ctrl.sv
// Sequencing state machine: update, main result, end-of-series flush.
`default_nettype none

module cbsd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cbsd_pkg::cbsd_status_t status_i,
  output cbsd_pkg::cbsd_cmd_t    cmd_o
);

  import cbsd_pkg::*;

  cbsd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_OLDEST;
    state_d      = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.idle   = 1'b1;
        cmd_o.rd_sel = RD_OLDEST;
        if (status_i.take) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_MAIN;
      end
      ST_MAIN: begin
        cmd_o.set_k = 1'b1;
        if (status_i.main_emit) begin
          state_d = ST_EM_RD;
        end else if (status_i.series_end) begin
          state_d = ST_FL_STEP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EM_RD: begin
        cmd_o.rd_sel = RD_CENTER;
        state_d      = ST_EM_EVAL;
      end
      ST_EM_EVAL: begin
        cmd_o.capture = 1'b1;
        if (status_i.raw) begin
          state_d = ST_EM_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_EM_DIV;
        end
      end
      ST_EM_DIV: begin
        if (!status_i.div_busy) begin
          state_d = ST_EM_OUT;
        end
      end
      ST_EM_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = status_i.series_end ? ST_FL_STEP : ST_IDLE;
        end
      end
      ST_FL_STEP: begin
        if (status_i.k_zero) begin
          cmd_o.restart = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.step_k = 1'b1;
          state_d      = ST_FL_CHK;
        end
      end
      ST_FL_CHK: begin
        cmd_o.rd_sel = RD_DROP;
        if (status_i.flush_sub) begin
          state_d = ST_FL_SUB;
        end else if (status_i.flush_emit) begin
          state_d = ST_EM_RD;
        end else begin
          state_d = ST_FL_STEP;
        end
      end
      ST_FL_SUB: begin
        cmd_o.drop = 1'b1;
        state_d    = status_i.flush_emit ? ST_EM_RD : ST_FL_STEP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/cbsd_dp.sv
// Datapath: configuration, sample ring, running sum, divider and result register.
`default_nettype none

module cbsd_dp #(
  parameter int MAX_HALF_WINDOW = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cbsd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [cbsd_pkg::CFG_BITS-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  input  logic [cbsd_pkg::FREQ_BITS-1:0]      frequency_i,
  input  logic [cbsd_pkg::SAMPLE_BITS-1:0]    sample_value_i,
  input  logic                                series_end_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [cbsd_pkg::FREQ_BITS-1:0]      out_frequency_o,
  output logic [cbsd_pkg::SAMPLE_BITS-1:0]    out_value_o,
  output logic                                kept_o,
  output logic                                run_last_o,
  input  cbsd_pkg::cbsd_cmd_t                 cmd_i,
  output cbsd_pkg::cbsd_status_t              status_o
);

  import cbsd_pkg::*;

  localparam int RING_DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CW         = $clog2(2 * RING_DEPTH);
  localparam int SUM_W      = SAMPLE_BITS + $clog2(RING_DEPTH);
  localparam int ENTRY_W    = FREQ_BITS + SAMPLE_BITS;

  logic [HW_BITS-1:0]     hw_q;
  logic [FACTOR_BITS-1:0] fac_q;
  logic [FREQ_BITS-1:0]   start_q;
  logic [FREQ_BITS-1:0]   low_q;
  logic [FREQ_BITS-1:0]   high_q;

  logic cfg_hw_wr, cfg_fac_wr, cfg_start_wr, cfg_low_wr, cfg_high_wr;
  logic restart;

  logic [FACTOR_BITS-1:0] fac_eff;
  logic [FACTOR_BITS-1:0] cfg_fac_eff;
  logic [FACTOR_BITS-1:0] restart_fac;
  logic [CW-1:0]          h;
  logic [CW-1:0]          w;

  logic [SUM_W-1:0]       sum_q;
  logic [CW-1:0]          seen_q;
  logic [PTR_W-1:0]       ptr_q;
  logic [FACTOR_BITS-1:0] phase_q;
  logic [CW-1:0]          k_q;
  logic [CW-1:0]          cnt_q;
  logic                   flush_q;
  logic                   end_q;

  logic [FREQ_BITS-1:0]   f_in_q;
  logic [SAMPLE_BITS-1:0] s_in_q;
  logic [FREQ_BITS-1:0]   cur_freq_q;
  logic [SAMPLE_BITS-1:0] raw_val_q;
  logic                   raw_q;

  logic [ENTRY_W-1:0]     mem [RING_DEPTH];
  logic [ENTRY_W-1:0]     rdata_q;
  logic [FREQ_BITS-1:0]   rd_freq;
  logic [SAMPLE_BITS-1:0] rd_sample;
  logic [CW-1:0]          rd_off;
  logic [CW-1:0]          ptr_ext;
  logic [PTR_W-1:0]       raddr;

  logic [SUM_W-1:0]       old_sample;
  logic [SUM_W-1:0]       sum_upd;
  logic                   take;
  logic                   is_raw;
  logic                   dec;
  logic                   band;
  logic                   last;
  logic [FACTOR_BITS-1:0] phase_nxt;
  logic                   out_valid_q;
  logic                   out_free;
  logic                   div_busy;
  logic [SAMPLE_BITS-1:0] quotient;

  always_comb begin
    cfg_hw_wr    = 1'b0;
    cfg_fac_wr   = 1'b0;
    cfg_start_wr = 1'b0;
    cfg_low_wr   = 1'b0;
    cfg_high_wr  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_HALF_WINDOW:  cfg_hw_wr    = 1'b1;
        REG_DECIMATION:   cfg_fac_wr   = 1'b1;
        REG_SMOOTH_START: cfg_start_wr = 1'b1;
        REG_BAND_LOW:     cfg_low_wr   = 1'b1;
        REG_BAND_HIGH:    cfg_high_wr  = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q    <= RST_HALF_WINDOW;
      fac_q   <= RST_DECIMATION;
      start_q <= RST_SMOOTH_START;
      low_q   <= RST_BAND_LOW;
      high_q  <= RST_BAND_HIGH;
    end else begin
      if (cfg_hw_wr)    hw_q    <= cfg_data_i[HW_BITS-1:0];
      if (cfg_fac_wr)   fac_q   <= cfg_data_i[FACTOR_BITS-1:0];
      if (cfg_start_wr) start_q <= cfg_data_i[FREQ_BITS-1:0];
      if (cfg_low_wr)   low_q   <= cfg_data_i[FREQ_BITS-1:0];
      if (cfg_high_wr)  high_q  <= cfg_data_i[FREQ_BITS-1:0];
    end
  end

  assign fac_eff     = (fac_q == '0) ? FACTOR_BITS'(1) : fac_q;
  assign cfg_fac_eff = (cfg_data_i[FACTOR_BITS-1:0] == '0) ? FACTOR_BITS'(1)
                                                           : cfg_data_i[FACTOR_BITS-1:0];
  assign restart_fac = cfg_fac_wr ? cfg_fac_eff : fac_eff;
  assign restart     = cmd_i.restart || cfg_hw_wr || cfg_fac_wr;

  assign h = (32'(hw_q) > MAX_HALF_WINDOW) ? CW'(MAX_HALF_WINDOW) : CW'(hw_q);
  assign w = {h[CW-2:0], 1'b1};

  // Ring read address: ptr minus an offset, modulo the ring depth.
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_OLDEST: rd_off = w;
      RD_DROP:   rd_off = k_q + h + CW'(2);
      RD_CENTER: rd_off = k_q + CW'(1);
      default:   rd_off = w;
    endcase
    ptr_ext = CW'(ptr_q);
    if (ptr_ext >= rd_off) begin
      raddr = PTR_W'(ptr_ext - rd_off);
    end else begin
      raddr = PTR_W'(ptr_ext + CW'(RING_DEPTH) - rd_off);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem[ptr_q] <= {f_in_q, s_in_q};
    end
    rdata_q <= mem[raddr];
  end

  assign rd_freq   = rdata_q[ENTRY_W-1 -: FREQ_BITS];
  assign rd_sample = rdata_q[SAMPLE_BITS-1:0];

  assign take       = in_valid_i && cmd_i.idle;
  assign is_raw     = rd_freq < start_q;
  assign old_sample = (seen_q >= w) ? SUM_W'(rd_sample) : '0;
  assign sum_upd    = sum_q + SUM_W'(s_in_q) - old_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      seen_q  <= '0;
      ptr_q   <= '0;
      phase_q <= RST_DECIMATION;
    end else if (restart) begin
      sum_q   <= '0;
      seen_q  <= '0;
      ptr_q   <= '0;
      phase_q <= restart_fac;
    end else begin
      if (cmd_i.update) begin
        sum_q  <= sum_upd;
        ptr_q  <= (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
        seen_q <= (seen_q < CW'(RING_DEPTH)) ? seen_q + CW'(1) : seen_q;
      end
      if (cmd_i.drop) begin
        sum_q <= sum_q - SUM_W'(rd_sample);
      end
      if (cmd_i.out_load) begin
        phase_q <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      cnt_q   <= '0;
      flush_q <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      if (cmd_i.set_k) begin
        k_q     <= h;
        cnt_q   <= (seen_q < w) ? seen_q : w;
        flush_q <= 1'b0;
      end else if (cmd_i.step_k) begin
        k_q     <= k_q - CW'(1);
        flush_q <= 1'b1;
      end else if (cmd_i.drop) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (take) begin
        end_q <= series_end_i;
      end
    end
  end

  cbsd_div #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (CW),
    .QUOT_W    (SAMPLE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(sum_q),
    .divisor_i (cnt_q),
    .busy_o    (div_busy),
    .quotient_o(quotient)
  );

  assign dec       = phase_q >= fac_eff;
  assign phase_nxt = (dec ? '0 : phase_q) + FACTOR_BITS'(1);
  assign band      = (cur_freq_q > low_q) && (cur_freq_q < high_q);
  assign last      = flush_q ? (k_q == '0) : (end_q && (h == '0));
  assign out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      f_in_q <= frequency_i;
      s_in_q <= sample_value_i;
    end
    if (cmd_i.capture) begin
      cur_freq_q <= rd_freq;
      raw_val_q  <= rd_sample;
      raw_q      <= is_raw;
    end
    if (cmd_i.out_load) begin
      out_frequency_o <= cur_freq_q;
      out_value_o     <= raw_q ? raw_val_q : quotient;
      kept_o          <= dec && band;
      run_last_o      <= last;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o            = '0;
    status_o.take       = take;
    status_o.series_end = end_q;
    status_o.main_emit  = seen_q >= h + CW'(2);
    status_o.k_zero     = k_q == '0;
    status_o.flush_sub  = seen_q >= k_q + h + CW'(2);
    status_o.flush_emit = seen_q >= k_q + CW'(2);
    status_o.raw        = is_raw;
    status_o.div_busy   = div_busy;
    status_o.out_free   = out_free;
  end

endmodule

`default_nettype wire

// File: design/centered_boxcar_smooth_decimate_core.sv
// Top level of the centred boxcar smoother with decimation and band selection.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_ready_o frequency_i, sample_value_i, series_end_i
//  out      output     out_valid_o/out_ready_i out_frequency_o, out_value_o, kept_o,
//                                              run_last_o
//  cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// An item with no result passes the idle, update and main states. Each result is read
// from the ring and captured, the mean of an averaged result coming from a bit-serial
// divider that resolves one quotient bit a cycle, then loaded into the output register.
// A final item steps through each flushed position, dropping a sample where due, then
// restarts the series. Reset needs no clearing pass. A result waiting in the output
// register stalls the next result load until taken; one item is worked on at a time.
`default_nettype none

module centered_boxcar_smooth_decimate_core #(
  parameter int MAX_HALF_WINDOW = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cbsd_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [cbsd_pkg::CFG_BITS-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cbsd_pkg::FREQ_BITS-1:0]    frequency_i,
  input  logic [cbsd_pkg::SAMPLE_BITS-1:0]  sample_value_i,
  input  logic                              series_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cbsd_pkg::FREQ_BITS-1:0]    out_frequency_o,
  output logic [cbsd_pkg::SAMPLE_BITS-1:0]  out_value_o,
  output logic                              kept_o,
  output logic                              run_last_o
);

  import cbsd_pkg::*;

  cbsd_cmd_t    cmd;
  cbsd_status_t status;

  cbsd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .cmd_o   (cmd)
  );

  cbsd_dp #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .frequency_i    (frequency_i),
    .sample_value_i (sample_value_i),
    .series_end_i   (series_end_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_frequency_o(out_frequency_o),
    .out_value_o    (out_value_o),
    .kept_o         (kept_o),
    .run_last_o     (run_last_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

  assign in_ready_o = cmd.idle;

endmodule

`default_nettype wire

// File: design/cbsd_chk.sv
// Port-level checks of the smoother, bound to the top level.
`default_nettype none

module cbsd_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [cbsd_pkg::FREQ_BITS-1:0]    out_frequency_o,
  input logic [cbsd_pkg::SAMPLE_BITS-1:0]  out_value_o,
  input logic                              kept_o,
  input logic                              run_last_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_frequency_o) &&
      $stable(out_value_o) && $stable(kept_o) && $stable(run_last_o))
    else $error("stalled result changed");

  // An accepted transaction keeps the input closed while the sum is updated.
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input reopened during update");

  // Present no unknown bits on a result.
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({out_frequency_o, out_value_o, kept_o, run_last_o}))
    else $error("unknown bits on a presented result");

endmodule

bind centered_boxcar_smooth_decimate_core cbsd_chk u_cbsd_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_frequency_o(out_frequency_o),
  .out_value_o    (out_value_o),
  .kept_o         (kept_o),
  .run_last_o     (run_last_o)
);

`default_nettype wire

// File: bench/centered_boxcar_smooth_decimate_core_tb.sv
// Self-checking bench for the centred boxcar smoother: directed and random series against a predictor.
`timescale 1ns / 100ps

module centered_boxcar_smooth_decimate_core_tb;
  import cbsd_pkg::*;

  localparam int unsigned RING_DEPTH   = 31;
  localparam int unsigned FREQ_DEPTH   = 16;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned STALL_AT     = 160;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_BINS   = 38;
  localparam int          TIMEOUT_NS   = 50_000_000;

  typedef struct {
    logic [FREQ_BITS-1:0]   freq;
    logic [SAMPLE_BITS-1:0] value;
    logic                   last;
  } bin_t;

  typedef struct {
    logic [FREQ_BITS-1:0]   freq;
    logic [SAMPLE_BITS-1:0] value;
    logic                   kept;
    logic                   run_last;
  } point_t;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    cfg_we_i        = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i     = '0;
  logic [CFG_BITS-1:0]     cfg_data_i      = '0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_ready_o;
  logic [FREQ_BITS-1:0]    frequency_i     = '0;
  logic [SAMPLE_BITS-1:0]  sample_value_i  = '0;
  logic                    series_end_i    = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i     = 1'b0;
  logic [FREQ_BITS-1:0]    out_frequency_o;
  logic [SAMPLE_BITS-1:0]  out_value_o;
  logic                    kept_o;
  logic                    run_last_o;

  centered_boxcar_smooth_decimate_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .frequency_i     (frequency_i),
    .sample_value_i  (sample_value_i),
    .series_end_i    (series_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_frequency_o (out_frequency_o),
    .out_value_o     (out_value_o),
    .kept_o          (kept_o),
    .run_last_o      (run_last_o)
  );

  bin_t        bins_to_send[$];
  point_t      points_due[$];
  int unsigned mismatches = 0;
  int unsigned bins_taken = 0;
  int unsigned send_gap   = 0;
  int unsigned ack_wait   = 0;
  int unsigned ack_next;
  int unsigned stall_left = 0;
  logic        stall_done = 1'b0;
  logic        src_calm   = 1'b0;
  logic        snk_calm   = 1'b0;

  // shadow of the block: configuration and series state
  logic [HW_BITS-1:0]     hw_reg;
  logic [FACTOR_BITS-1:0] dec_reg;
  logic [FREQ_BITS-1:0]   start_reg;
  logic [FREQ_BITS-1:0]   low_reg;
  logic [FREQ_BITS-1:0]   high_reg;
  logic [SAMPLE_BITS-1:0] smp_ring [RING_DEPTH];
  logic [FREQ_BITS-1:0]   frq_ring [FREQ_DEPTH];
  logic [36:0]            run_sum;
  int unsigned            n_seen;
  int unsigned            wr_ptr;
  int unsigned            dec_phase;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("%0t ns mismatch: %s", $time, what);
  endtask

  function automatic int unsigned keep_every();
    return (dec_reg == '0) ? 1 : int'(dec_reg);
  endfunction

  function automatic void restart_series();
    run_sum   = '0;
    n_seen    = 0;
    wr_ptr    = 0;
    dec_phase = keep_every();
  endfunction

  function automatic void reset_shadow();
    hw_reg    = RST_HALF_WINDOW;
    dec_reg   = RST_DECIMATION;
    start_reg = RST_SMOOTH_START;
    low_reg   = RST_BAND_LOW;
    high_reg  = RST_BAND_HIGH;
    foreach (smp_ring[i]) smp_ring[i] = '0;
    foreach (frq_ring[i]) frq_ring[i] = '0;
    restart_series();
  endfunction

  function automatic void shadow_write(input cbsd_reg_e idx, input logic [CFG_BITS-1:0] d);
    case (idx)
      REG_HALF_WINDOW: begin
        hw_reg = d[HW_BITS-1:0];
        restart_series();
      end
      REG_DECIMATION: begin
        dec_reg = d[FACTOR_BITS-1:0];
        restart_series();
      end
      REG_SMOOTH_START: start_reg = d;
      REG_BAND_LOW:     low_reg   = d;
      REG_BAND_HIGH:    high_reg  = d;
      default: ;
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] sample_ago(input int unsigned k);
    return smp_ring[(wr_ptr + RING_DEPTH - 1 - (k % RING_DEPTH)) % RING_DEPTH];
  endfunction

  function automatic void predict_point(input int unsigned k, input logic [36:0] acc,
                                        input int unsigned cnt, input logic fin);
    point_t      p;
    logic        pass_dec;
    int unsigned div;
    p.freq = frq_ring[k % FREQ_DEPTH];
    div    = (cnt == 0) ? 1 : cnt;
    if (p.freq < start_reg) p.value = sample_ago(k);
    else p.value = SAMPLE_BITS'(acc / 37'(div));
    pass_dec = (dec_phase >= keep_every());
    if (pass_dec) dec_phase = 0;
    dec_phase  = (dec_phase + 1) & 32'hFF;
    p.kept     = pass_dec && (p.freq > low_reg) && (p.freq < high_reg);
    p.run_last = fin;
    points_due.push_back(p);
  endfunction

  function automatic void smooth_bin(input bin_t b);
    int unsigned h, w, n, cnt, k, i;
    logic [36:0] acc;
    h = hw_reg;
    w = 2 * h + 1;
    for (i = FREQ_DEPTH - 1; i > 0; i--) frq_ring[i] = frq_ring[i-1];
    frq_ring[0] = b.freq;
    if (n_seen >= w) run_sum = run_sum - sample_ago(w - 1);
    smp_ring[wr_ptr] = b.value;
    wr_ptr  = (wr_ptr + 1) % RING_DEPTH;
    run_sum = run_sum + b.value;
    if (n_seen < RING_DEPTH) n_seen++;
    n   = n_seen;
    cnt = (n < w) ? n : w;
    if (n >= h + 2) predict_point(h, run_sum, cnt, b.last && (h == 0));
    if (b.last) begin
      acc = run_sum;
      k   = h;
      while (k > 0) begin
        k--;
        // drop the sample leaving the front of the window
        if (n >= k + h + 2) begin
          acc = acc - sample_ago(k + 1 + h);
          cnt--;
        end
        if (n >= k + 2) predict_point(k, acc, cnt, k == 0);
      end
      restart_series();
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        smooth_bin('{freq: frequency_i, value: sample_value_i, last: series_end_i});
        bins_taken <= bins_taken + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (bins_to_send.size() != 0) begin
          frequency_i    <= bins_to_send[0].freq;
          sample_value_i <= bins_to_send[0].value;
          series_end_i   <= bins_to_send[0].last;
          void'(bins_to_send.pop_front());
          in_valid_i     <= 1'b1;
          send_gap       <= src_calm ? 0 : $urandom_range(0, 15);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && bins_taken >= STALL_AT) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ack_wait    <= 0;
    end else begin
      ack_next = ack_wait;
      if (out_valid_o && out_ready_i) begin
        if (points_due.size() == 0) begin
          flag_mismatch($sformatf("result with nothing due: freq %h value %h",
                                  out_frequency_o, out_value_o));
        end else begin
          if (out_frequency_o !== points_due[0].freq)
            flag_mismatch($sformatf("out_frequency got %h want %h",
                                    out_frequency_o, points_due[0].freq));
          if (out_value_o !== points_due[0].value)
            flag_mismatch($sformatf("out_value got %h want %h (freq %h)",
                                    out_value_o, points_due[0].value, points_due[0].freq));
          if (kept_o !== points_due[0].kept)
            flag_mismatch($sformatf("kept got %b want %b (freq %h)",
                                    kept_o, points_due[0].kept, points_due[0].freq));
          if (run_last_o !== points_due[0].run_last)
            flag_mismatch($sformatf("run_last got %b want %b (freq %h)",
                                    run_last_o, points_due[0].run_last, points_due[0].freq));
          void'(points_due.pop_front());
        end
        ack_next = snk_calm ? 0 : $urandom_range(0, 15);
      end else if (ack_next != 0) begin
        ack_next--;
      end
      ack_wait    <= ack_next;
      out_ready_i <= (ack_next == 0) && (stall_left == 0);
    end
  end

  task automatic write_reg(input cbsd_reg_e idx, input logic [CFG_BITS-1:0] d);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    shadow_write(idx, d);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (bins_to_send.size() != 0 || in_valid_i || points_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic plan_phase(input int unsigned n_bins);
    bin_t            b;
    int unsigned     h, f, len, made, i;
    logic [31:0]     lo, hi, tmp;
    logic            cut;
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0:       h = 0;
        1:       h = 15;
        default: h = $urandom_range(1, 14);
      endcase
      write_reg(REG_HALF_WINDOW, ($urandom & 32'hFFFF_FFF0) | h);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 4))
        0:       f = 1;
        1:       f = 255;
        2:       f = 0;
        default: f = $urandom_range(2, 7);
      endcase
      write_reg(REG_DECIMATION, ($urandom & 32'hFFFF_FF00) | f);
    end
    if ($urandom_range(0, 1) != 0) begin
      case ($urandom_range(0, 3))
        0:       tmp = '0;
        1:       tmp = '1;
        default: tmp = $urandom;
      endcase
      write_reg(REG_SMOOTH_START, tmp);
    end
    if ($urandom_range(0, 1) != 0) begin
      lo = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom;
      hi = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom;
      if (lo > hi) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      write_reg(REG_BAND_LOW, lo);
      write_reg(REG_BAND_HIGH, hi);
    end
    @(negedge clk_i);
    src_calm = ($urandom_range(0, 3) == 0);
    snk_calm = ($urandom_range(0, 3) == 0);
    cut  = ($urandom_range(0, 2) == 0);
    h    = hw_reg;
    made = 0;
    while (made < n_bins) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 2 * h + 4);
      for (i = 0; i < len && made < n_bins; i++) begin
        case ($urandom_range(0, 3))
          0, 1: b.freq = $urandom;
          2:    b.freq = start_reg + $urandom_range(0, 4) - 2;
          default: b.freq = (($urandom_range(0, 1) != 0) ? low_reg : high_reg)
                            + $urandom_range(0, 2) - 1;
        endcase
        case ($urandom_range(0, 7))
          0:       b.value = '0;
          1:       b.value = '1;
          default: b.value = $urandom;
        endcase
        b.last = (i == len - 1);
        if (made == n_bins - 1) b.last = !cut;
        bins_to_send.push_back(b);
        made++;
      end
    end
  endtask

  initial begin
    int unsigned p;
    reset_shadow();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one-sample series, then threshold and band edges
    @(negedge clk_i);
    bins_to_send.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    bins_to_send.push_back('{32'd3354,      32'hFFFF_FFFF, 1'b0});
    bins_to_send.push_back('{32'd3355,      32'h1234_5678, 1'b0});
    bins_to_send.push_back('{32'd17,        32'd1,         1'b0});
    bins_to_send.push_back('{32'd18,        32'd0,         1'b0});
    bins_to_send.push_back('{32'd25165823,  32'hFFFF_FFFF, 1'b0});
    bins_to_send.push_back('{32'd25165824,  32'd5,         1'b0});
    bins_to_send.push_back('{32'd0,         32'd7,         1'b1});
    settle();

    // widest window, zero factor, full band: one end marker flushes sixteen results
    write_reg(REG_HALF_WINDOW,  32'hFFFF_FFFF);
    write_reg(REG_DECIMATION,   32'hFFFF_FF00);
    write_reg(REG_SMOOTH_START, 32'h0);
    write_reg(REG_BAND_LOW,     32'h0);
    write_reg(REG_BAND_HIGH,    32'hFFFF_FFFF);
    @(negedge clk_i);
    for (p = 0; p < 17; p++)
      bins_to_send.push_back('{32'h0100_0000 * p, (p % 2 == 0) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE,
                               p == 16});
    settle();

    for (p = 0; p < PHASES; p++) begin
      plan_phase(PHASE_BINS);
      settle();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
